/* rtl/core/swoc_pkg.sv */
// Package for the sliding window outcome counter.
// Holds sizes, action and register codes, request types and a saturating increment helper.
// No dependencies.
package swoc_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int COUNT_BITS   = 24;
    localparam int TIME_W       = 32;
    localparam int WIN_W        = 7;
    localparam int IDX_W        = $clog2(MAX_WINDOW);
    localparam int SUM_W        = 30;
    localparam int ACT_W        = 2;
    localparam int DIV_CNT_W    = $clog2(TIME_W);
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam int WINDOW_RESET = 10;

    // Action codes carried by an input request.
    localparam logic [ACT_W-1:0] ACT_SUCCESS = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FAIL    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_OBSERVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

    // Register index of the window length register.
    localparam logic [ADDR_W-3:0] REG_WINDOW_LEN = '0;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIME_W-1:0] now_sec;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] window_total;
        logic [SUM_W-1:0] window_failures;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_HEAD,
        ST_ZERO,
        ST_SUM,
        ST_DRAIN,
        ST_DONE
    } swoc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic head_update;
        logic zero_step;
        logic sum_issue;
        logic out_load;
    } swoc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_done;
        logic zero_walk;
        logic zero_last;
        logic sum_last;
        logic out_free;
    } swoc_status_t;

    // Saturating increment of one bucket count.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        if (v == {COUNT_BITS{1'b1}})
        begin
            r = v;
        end
        else
        begin
            r = v + COUNT_BITS'(1);
        end
        return r;
    endfunction

endpackage

/* rtl/core/swoc_mod.sv */
// Serial remainder unit: one restoring step per cycle over a 32-bit time.
// Depends on swoc_pkg.
module swoc_mod
    import swoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [WIN_W-1:0]  divisor,
    output logic              done,
    output logic [IDX_W-1:0]  rem
);

    logic                 running_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    quo_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [IDX_W:0]       trial;
    logic [IDX_W-1:0]     rem_next;
    logic                 last_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, quo_reg[TIME_W-1]};
        if (trial >= divisor)
        begin
            rem_next = IDX_W'(trial - divisor);
        end
        else
        begin
            rem_next = IDX_W'(trial);
        end
        last_step = (cnt_reg == DIV_CNT_W'(TIME_W - 1));
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= running_reg && last_step;
            if (start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last_step)
                begin
                    running_reg <= 1'b0;
                end
            end
        end
    end

    // Quotient shifter and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (running_reg)
        begin
            quo_reg <= {quo_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/core/swoc_datapath.sv */
// Datapath: window register, bucket memory with valid bits, head time,
// zeroing walk, summing walk and output register. Depends on swoc_pkg, swoc_mod.
module swoc_datapath
    import swoc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  swoc_cmd_t          cmd,
    output swoc_status_t       status,
    input  in_item_t           in_data,
    input  logic               cfg_we,
    input  logic [WIN_W-1:0]   cfg_wdata,
    output logic [WIN_W-1:0]   window_len,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    logic [WIN_W-1:0]          window_len_reg;
    logic [MAX_WINDOW-1:0]     valid_reg;
    logic [2*COUNT_BITS-1:0]   mem [MAX_WINDOW];
    logic [2*COUNT_BITS-1:0]   rd_data_reg;
    logic                      rd_hit_reg;
    logic                      rd_pend_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic [ACT_W-1:0]          action_reg;
    logic [TIME_W-1:0]         now_reg;
    logic [TIME_W-1:0]         head_sec_reg;
    logic [IDX_W-1:0]          head_slot_reg;
    logic                      head_known_reg;
    logic [IDX_W-1:0]          slot_reg;
    logic [IDX_W-1:0]          zero_ptr_reg;
    logic [WIN_W-1:0]          zero_cnt_reg;
    logic [IDX_W-1:0]          sum_addr_reg;
    logic [SUM_W-1:0]          acc_t_reg;
    logic [SUM_W-1:0]          acc_f_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic                      mod_done;
    logic [IDX_W-1:0]          mod_rem;
    logic [WIN_W-1:0]          cfg_clamped;
    logic [TIME_W-1:0]         gap;
    logic                      gap_small;
    logic                      advance;
    logic                      wipe_all;
    logic [IDX_W-1:0]          zero_first;
    logic [IDX_W-1:0]          zero_ptr_next;
    logic [COUNT_BITS-1:0]     entry_t;
    logic [COUNT_BITS-1:0]     entry_f;
    logic                      bump;
    logic [COUNT_BITS-1:0]     new_t;
    logic [COUNT_BITS-1:0]     new_f;
    logic [SUM_W:0]            sum_t;
    logic [SUM_W:0]            sum_f;

    // Remainder unit for the bucket index of the request time.
    swoc_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load_item),
        .dividend (in_data.now_sec),
        .divisor  (window_len_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Clamp a written window length into the supported range.
    always_comb
    begin
        priority if (cfg_wdata == '0)
        begin
            cfg_clamped = WIN_W'(1);
        end
        else if (cfg_wdata > WIN_W'(MAX_WINDOW))
        begin
            cfg_clamped = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_clamped = cfg_wdata;
        end
    end

    // Head decision: how far time moves and which buckets it passes over.
    always_comb
    begin
        gap       = now_reg - head_sec_reg;
        gap_small = (gap[TIME_W-1:WIN_W] == '0) && (gap[WIN_W-1:0] < window_len_reg);
        advance   = (action_reg != ACT_CLEAR) && head_known_reg && (now_reg > head_sec_reg);
        wipe_all  = advance && !gap_small;
        if (({1'b0, head_slot_reg} + WIN_W'(1)) == window_len_reg)
        begin
            zero_first = '0;
        end
        else
        begin
            zero_first = head_slot_reg + IDX_W'(1);
        end
        if (({1'b0, zero_ptr_reg} + WIN_W'(1)) == window_len_reg)
        begin
            zero_ptr_next = '0;
        end
        else
        begin
            zero_ptr_next = zero_ptr_reg + IDX_W'(1);
        end
    end

    // Bucket update and saturating accumulation of the entry just read.
    always_comb
    begin
        entry_t = rd_hit_reg ? rd_data_reg[2*COUNT_BITS-1:COUNT_BITS] : '0;
        entry_f = rd_hit_reg ? rd_data_reg[COUNT_BITS-1:0] : '0;
        bump    = (rd_idx_reg == slot_reg)
                  && ((action_reg == ACT_SUCCESS) || (action_reg == ACT_FAIL));
        new_t   = bump ? sat_inc(entry_t) : entry_t;
        new_f   = (bump && (action_reg == ACT_FAIL)) ? sat_inc(entry_f) : entry_f;
        sum_t   = {1'b0, acc_t_reg} + (SUM_W + 1)'(new_t);
        sum_f   = {1'b0, acc_f_reg} + (SUM_W + 1)'(new_f);
    end

    // Configuration, valid bits and head state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WIN_W'(WINDOW_RESET);
            valid_reg      <= '0;
            head_known_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.sum_issue;
            if (cfg_we)
            begin
                window_len_reg <= cfg_clamped;
                valid_reg      <= '0;
                head_known_reg <= 1'b0;
            end
            else if (cmd.load_item && (in_data.action == ACT_CLEAR))
            begin
                valid_reg      <= '0;
                head_known_reg <= 1'b0;
            end
            else if (cmd.head_update)
            begin
                if (wipe_all)
                begin
                    valid_reg <= '0;
                end
                if (action_reg != ACT_CLEAR)
                begin
                    head_known_reg <= 1'b1;
                end
            end
            else if (cmd.zero_step)
            begin
                valid_reg[zero_ptr_reg] <= 1'b0;
            end
            else if (rd_pend_reg && bump)
            begin
                valid_reg[rd_idx_reg] <= 1'b1;
            end
            // Output register: holds a result until it is taken.
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, walk counters and accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= in_data.action;
            now_reg    <= in_data.now_sec;
        end
        if (cmd.head_update)
        begin
            slot_reg     <= mod_rem;
            zero_ptr_reg <= zero_first;
            zero_cnt_reg <= gap[WIN_W-1:0];
            sum_addr_reg <= '0;
            acc_t_reg    <= '0;
            acc_f_reg    <= '0;
            if ((action_reg != ACT_CLEAR) && (!head_known_reg || advance))
            begin
                head_sec_reg  <= now_reg;
                head_slot_reg <= mod_rem;
            end
        end
        if (cmd.zero_step)
        begin
            zero_ptr_reg <= zero_ptr_next;
            zero_cnt_reg <= zero_cnt_reg - WIN_W'(1);
        end
        if (cmd.sum_issue)
        begin
            sum_addr_reg <= sum_addr_reg + IDX_W'(1);
        end
        if (rd_pend_reg)
        begin
            acc_t_reg <= sum_t[SUM_W] ? {SUM_W{1'b1}} : sum_t[SUM_W-1:0];
            acc_f_reg <= sum_f[SUM_W] ? {SUM_W{1'b1}} : sum_f[SUM_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg.window_total    <= acc_t_reg;
            out_data_reg.window_failures <= acc_f_reg;
        end
    end

    // Bucket memory: one read port for the summing walk, one write port
    // for the incremented bucket in the cycle after its read.
    always_ff @(posedge clk)
    begin
        if (cmd.sum_issue)
        begin
            rd_data_reg <= mem[sum_addr_reg];
            rd_hit_reg  <= valid_reg[sum_addr_reg];
            rd_idx_reg  <= sum_addr_reg;
        end
        if (rd_pend_reg && bump)
        begin
            mem[rd_idx_reg] <= {new_t, new_f};
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.mod_done  = mod_done;
        status.zero_walk = advance && gap_small;
        status.zero_last = (zero_cnt_reg == WIN_W'(1));
        status.sum_last  = (({1'b0, sum_addr_reg} + WIN_W'(1)) == window_len_reg);
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign window_len = window_len_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

/* rtl/core/swoc_ctrl.sv */
// Controller state machine: sequences the remainder, head update, zeroing
// walk, summing walk and result hand-off. Depends on swoc_pkg.
module swoc_ctrl
    import swoc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  swoc_status_t status,
    output swoc_cmd_t    cmd
);

    swoc_state_t state_reg;
    swoc_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                state_next = status.zero_walk ? ST_ZERO : ST_SUM;
            end
            ST_ZERO:
            begin
                if (status.zero_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (status.sum_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall        = (state_reg != ST_IDLE);
        cmd.load_item   = (state_reg == ST_IDLE) && in_valid;
        cmd.head_update = (state_reg == ST_HEAD);
        cmd.zero_step   = (state_reg == ST_ZERO);
        cmd.sum_issue   = (state_reg == ST_SUM);
        cmd.out_load    = (state_reg == ST_DONE) && status.out_free;
    end

endmodule

/* rtl/core/sliding_window_outcome_counter_top.sv */
// Top level of the sliding window outcome counter.
// Depends on swoc_pkg, swoc_ctrl and swoc_datapath.
//
// Usage:
// - Input channel (in_valid, in_stall, in_data) carries one request: an action
//   (success, failure, observe, clear) and the current time in seconds.
// - Output channel (out_valid, out_stall, out_data) returns one result per
//   request: the window sums of totals and failures after that request.
// - The APB port holds one register, the window length at address 0. Write it
//   only while the block is idle; any write empties the window.
// - One request is worked at a time. The bucket is picked by the bit-serial
//   remainder unit (one bit per cycle over 32 bits). When time moves forward
//   by less than W, the window length, a zeroing walk clears the G buckets
//   passed over (G is 0 otherwise); then the summing walk reads all W buckets
//   of the single-read-port bucket memory. The next request is accepted in
//   the cycle after the load of a result at the earliest.
// - A finished result sits in the output register; the next request is
//   accepted while it waits, and its own result is held back until the
//   register is free. A stalled result keeps its value.
// - Reset empties all buckets, forgets the head time and sets the window
//   length to 10. No clearing pass is needed.
module sliding_window_outcome_counter_top
    import swoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    swoc_cmd_t        cmd;
    swoc_status_t     status;
    logic             cfg_we;
    logic             reg_hit;
    logic [WIN_W-1:0] window_len;

    // Register decode for the configuration port.
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_WINDOW_LEN);
    assign cfg_we  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DATA_W'(window_len) : '0;

    swoc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    swoc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_data    (in_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata[WIN_W-1:0]),
        .window_len (window_len),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

`ifndef ASSERT_OFF
    // A request in work blocks the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in work");

    // A new result never overwrites one that is still held.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("held result overwritten");

    // The zeroing walk and the summing walk never run together.
    a_walks_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.zero_step |-> !cmd.sum_issue && !cmd.head_update)
        else $error("zeroing walk overlaps another step");
`endif

endmodule
